FILE: rtl/itrt_pkg.sv
// ----------------------------------------------------------------------------
// itrt_pkg: shared types and constants for the radix text converter
// Field widths, character codes, the queue entry type and the back-end states.
// ----------------------------------------------------------------------------
package itrt_pkg;

  // field widths
  localparam int NUMBER_W = 32;
  localparam int RADIX_W  = 5;
  localparam int CHAR_W   = 8;
  localparam int COUNT_W  = 6;
  localparam int BUF_W    = 8;
  localparam int DIGIT_W  = 4;

  // sizing defaults
  localparam int MAX_DIGITS_DEF = 32;
  localparam int QUEUE_DEPTH    = 2;

  // limits and character codes
  localparam logic [BUF_W-1:0]   BUF_SIZE_RESET = 8'd34;
  localparam logic [BUF_W-1:0]   BUF_MIN        = 8'd2;
  localparam logic [RADIX_W-1:0] RADIX_MIN      = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX      = 5'd16;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN      = 4'd10;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO      = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0]  CHAR_ALPHA     = 8'h57;  // 'a' minus ten

  // one classified request waiting for the back end
  typedef struct packed {
    logic [NUMBER_W-1:0] number;
    logic [RADIX_W-1:0]  radix;
    logic                bad;     // radix or buffer size rules it out
  } itrt_job_t;

  // queue handshake, source side
  typedef struct packed {
    logic      valid;
    itrt_job_t job;
  } itrt_push_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_EMIT,
    B_FAIL
  } back_state_t;

endpackage

FILE: rtl/itrt_req_if.sv
// ----------------------------------------------------------------------------
// itrt_req_if: request channel of the radix text converter
// Valid/ready handshake carrying the number and its radix.
// ----------------------------------------------------------------------------
interface itrt_req_if;
  logic                          valid;
  logic                          ready;
  logic [itrt_pkg::NUMBER_W-1:0] number;
  logic [itrt_pkg::RADIX_W-1:0]  radix;

  modport source (output valid, output number, output radix, input ready);
  modport sink   (input valid, input number, input radix, output ready);
endinterface

FILE: rtl/itrt_rsp_if.sv
// ----------------------------------------------------------------------------
// itrt_rsp_if: result channel of the radix text converter
// Valid/ready handshake carrying one character of a conversion.
// ----------------------------------------------------------------------------
interface itrt_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [itrt_pkg::CHAR_W-1:0]  digit_char;
  logic                         last_char;
  logic                         failed;
  logic [itrt_pkg::COUNT_W-1:0] digit_count;

  modport source (output valid, output digit_char, output last_char, output failed,
                  output digit_count, input ready);
  modport sink   (input valid, input digit_char, input last_char, input failed,
                  input digit_count, output ready);
endinterface

FILE: rtl/itrt_front.sv
// ----------------------------------------------------------------------------
// itrt_front: request classifier
// Accepts requests, flags those whose radix or buffer size rules them out,
// and hands them to the queue.
// ----------------------------------------------------------------------------
module itrt_front (
  input  logic                       [itrt_pkg::BUF_W-1:0] buffer_size,
  itrt_req_if.sink                   req,
  output itrt_pkg::itrt_push_t       push,
  input  logic                       push_ready
);

  logic radix_bad;
  logic buf_bad;

  // classification
  assign radix_bad = (req.radix < itrt_pkg::RADIX_MIN) || (req.radix > itrt_pkg::RADIX_MAX);
  assign buf_bad   = buffer_size < itrt_pkg::BUF_MIN;

  assign push.valid      = req.valid;
  assign push.job.number = req.number;
  assign push.job.radix  = req.radix;
  assign push.job.bad    = radix_bad || buf_bad;
  assign req.ready       = push_ready;

endmodule

FILE: rtl/itrt_queue.sv
// ----------------------------------------------------------------------------
// itrt_queue: short request queue
// Register FIFO between the classifier and the conversion engine.
// ----------------------------------------------------------------------------
module itrt_queue #(
  parameter int DEPTH = itrt_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  itrt_pkg::itrt_push_t push,
  output logic                 push_ready,
  output logic                 pop_valid,
  output itrt_pkg::itrt_job_t  pop_job,
  input  logic                 pop_ready
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  itrt_pkg::itrt_job_t entries [DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    count;
  logic                do_push;
  logic                do_pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_job    = entries[rd_ptr];
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.job;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // fill level never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue fill level exceeds depth");

endmodule

FILE: rtl/itrt_back.sv
// ----------------------------------------------------------------------------
// itrt_back: conversion engine
// Divides by the radix one quotient byte per cycle, stores the remainders,
// then plays the digits out most significant first through an output register.
// ----------------------------------------------------------------------------
module itrt_back #(
  parameter int MAX_DIGITS = itrt_pkg::MAX_DIGITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [itrt_pkg::BUF_W-1:0]   buffer_size,
  input  logic                         job_valid,
  input  itrt_pkg::itrt_job_t          job,
  output logic                         job_ready,
  itrt_rsp_if.source                   rsp
);

  localparam int IDX_W = $clog2(MAX_DIGITS);
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  itrt_pkg::back_state_t state, state_next;

  logic [itrt_pkg::RADIX_W-1:0]  radix;
  logic [itrt_pkg::NUMBER_W-1:0] quot;
  logic [itrt_pkg::DIGIT_W-1:0]  rem;
  logic [1:0]                    byte_sel;
  logic [CNT_W-1:0]              cnt;
  logic [IDX_W-1:0]              rd_idx;
  logic                          rd_pend;
  logic                          rd_last;
  logic [itrt_pkg::DIGIT_W-1:0]  rd_data;
  logic [itrt_pkg::DIGIT_W-1:0]  store [MAX_DIGITS];

  logic                          out_valid;
  logic [itrt_pkg::CHAR_W-1:0]   out_char;
  logic                          out_last;
  logic                          out_failed;
  logic [itrt_pkg::COUNT_W-1:0]  out_count;

  // divider step signals
  logic [itrt_pkg::RADIX_W-1:0]  trial;
  logic [itrt_pkg::DIGIT_W-1:0]  div_rem;
  logic [7:0]                    div_q;
  logic [itrt_pkg::NUMBER_W-1:0] q_new;
  logic [CNT_W-1:0]              cnt_inc;
  logic                          div_last;
  logic                          more;
  logic                          too_long;

  // control strobes
  logic load_job;
  logic div_step;
  logic rd_issue;
  logic load_digit;
  logic load_fail;
  logic out_free;

  function automatic logic [itrt_pkg::CHAR_W-1:0] to_char(
    input logic [itrt_pkg::DIGIT_W-1:0] d
  );
    if (d >= itrt_pkg::DIGIT_TEN) begin
      return itrt_pkg::CHAR_ALPHA + itrt_pkg::CHAR_W'(d);
    end
    return itrt_pkg::CHAR_ZERO + itrt_pkg::CHAR_W'(d);
  endfunction

  // one quotient byte: eight restoring steps, remainder stays below radix
  always_comb begin
    div_rem = rem;
    trial   = '0;
    div_q   = '0;
    for (int i = 7; i >= 0; i--) begin
      trial = {div_rem, quot[24 + i]};
      if (trial >= radix) begin
        div_q[i] = 1'b1;
        div_rem  = itrt_pkg::DIGIT_W'(trial - radix);
      end else begin
        div_rem  = trial[itrt_pkg::DIGIT_W-1:0];
      end
    end
  end

  assign q_new    = {quot[23:0], div_q};
  assign cnt_inc  = cnt + 1'b1;
  assign div_last = byte_sel == 2'd3;
  assign more     = (q_new != '0) && (32'(cnt_inc) < 32'(buffer_size)) &&
                    (32'(cnt_inc) < 32'(MAX_DIGITS));
  assign too_long = (q_new != '0) || ((32'(cnt_inc) + 32'd1) >= 32'(buffer_size));
  assign out_free = !out_valid || rsp.ready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itrt_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and strobes
  always_comb begin
    state_next = state;
    job_ready  = 1'b0;
    load_job   = 1'b0;
    div_step   = 1'b0;
    rd_issue   = 1'b0;
    load_digit = 1'b0;
    load_fail  = 1'b0;
    case (state)
      itrt_pkg::B_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) begin
          load_job   = 1'b1;
          state_next = job.bad ? itrt_pkg::B_FAIL : itrt_pkg::B_DIV;
        end
      end
      itrt_pkg::B_DIV: begin
        div_step = 1'b1;
        if (div_last && !more) begin
          state_next = too_long ? itrt_pkg::B_FAIL : itrt_pkg::B_EMIT;
        end
      end
      itrt_pkg::B_EMIT: begin
        if (rd_pend) begin
          load_digit = 1'b1;
          if (rd_last) begin
            state_next = itrt_pkg::B_IDLE;
          end
        end else if (out_free) begin
          rd_issue = 1'b1;
        end
      end
      itrt_pkg::B_FAIL: begin
        if (out_free) begin
          load_fail  = 1'b1;
          state_next = itrt_pkg::B_IDLE;
        end
      end
      default: begin
        state_next = itrt_pkg::B_IDLE;
      end
    endcase
  end

  // division control and held state
  always_ff @(posedge clk) begin
    if (rst) begin
      quot     <= '0;
      cnt      <= '0;
      byte_sel <= '0;
      rd_pend  <= 1'b0;
    end else begin
      if (load_job) begin
        quot     <= job.number;
        byte_sel <= '0;
        if (!job.bad) begin
          cnt <= '0;
        end
      end else if (div_step) begin
        quot     <= q_new;
        byte_sel <= byte_sel + 1'b1;
        if (div_last) begin
          cnt <= cnt_inc;
        end
      end
      rd_pend <= rd_issue;
    end
  end

  // divider operands and read index
  always_ff @(posedge clk) begin
    if (load_job) begin
      radix <= job.radix;
      rem   <= '0;
    end else if (div_step) begin
      rem <= div_last ? '0 : div_rem;
      if (div_last) begin
        rd_idx <= IDX_W'(cnt);
      end
    end else if (rd_issue) begin
      rd_idx  <= rd_idx - 1'b1;
      rd_last <= rd_idx == '0;
    end
  end

  // digit store
  always_ff @(posedge clk) begin
    if (div_step && div_last) begin
      store[IDX_W'(cnt)] <= div_rem;
    end
    if (rd_issue) begin
      rd_data <= store[rd_idx];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_digit || load_fail) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_digit) begin
      out_char   <= to_char(rd_data);
      out_last   <= rd_last;
      out_failed <= 1'b0;
      out_count  <= itrt_pkg::COUNT_W'(cnt);
    end else if (load_fail) begin
      out_char   <= '0;
      out_last   <= 1'b1;
      out_failed <= 1'b1;
      out_count  <= '0;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.digit_char  = out_char;
  assign rsp.last_char   = out_last;
  assign rsp.failed      = out_failed;
  assign rsp.digit_count = out_count;

  // a pending store read only lands in an empty output register
  a_read_lands_free: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> (!out_valid && state == itrt_pkg::B_EMIT))
    else $error("store read pending while output register is full");

  // the store index never runs past its depth while dividing
  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    (state == itrt_pkg::B_DIV) |-> (32'(cnt) < 32'(MAX_DIGITS)))
    else $error("digit count reached store depth during division");

  // every division starts on the top byte with a cleared remainder
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    (state == itrt_pkg::B_DIV && $past(state) == itrt_pkg::B_IDLE) |->
      (rem == '0 && byte_sel == 2'd0))
    else $error("division started mid-word");

endmodule

FILE: rtl/integer_to_radix_text_top.sv
// ----------------------------------------------------------------------------
// integer_to_radix_text_top: unsigned number to lower-case radix text
// Classifier, request queue and conversion engine, plus the buffer size register.
// ----------------------------------------------------------------------------
//  channel | direction | payload                                   | handshake
//  req     | in        | number[31:0], radix[4:0]                  | valid/ready
//  rsp     | out       | digit_char, last_char, failed, digit_count| valid/ready
//  cfg     | in        | cfg_wr_data[7:0] -> buffer_size           | cfg_wr_en
//
//  A conversion divides by the radix one quotient byte per cycle through an
//  eight-step compare/subtract, four quotient bytes for each digit, then reads
//  each digit from the digit store and loads it into the output register once free.
//  A failed request goes through the engine's fail state into the output register.
//  Reset is synchronous; buffer_size returns to 34 and the queue empties.
//  The queue takes up to two requests while the engine or rsp is stalled.
// ----------------------------------------------------------------------------
module integer_to_radix_text_top #(
  parameter int MAX_DIGITS  = itrt_pkg::MAX_DIGITS_DEF,
  parameter int QUEUE_DEPTH = itrt_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  itrt_req_if.sink                    req,
  itrt_rsp_if.source                  rsp,
  input  logic                        cfg_wr_en,
  input  logic [itrt_pkg::BUF_W-1:0]  cfg_wr_data
);

  logic [itrt_pkg::BUF_W-1:0] buffer_size;
  itrt_pkg::itrt_push_t       push;
  logic                       push_ready;
  logic                       job_valid;
  itrt_pkg::itrt_job_t        job;
  logic                       job_ready;

  // buffer size register
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size <= itrt_pkg::BUF_SIZE_RESET;
    end else if (cfg_wr_en) begin
      buffer_size <= cfg_wr_data;
    end
  end

  itrt_front u_front (
    .buffer_size (buffer_size),
    .req         (req),
    .push        (push),
    .push_ready  (push_ready)
  );

  itrt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .pop_valid  (job_valid),
    .pop_job    (job),
    .pop_ready  (job_ready)
  );

  itrt_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .buffer_size (buffer_size),
    .job_valid   (job_valid),
    .job         (job),
    .job_ready   (job_ready),
    .rsp         (rsp)
  );

endmodule

FILE: sim/integer_to_radix_text_top_test.sv
// ----------------------------------------------------------------------------
// integer_to_radix_text_top_test: self-checking bench for the radix text unit
// Sends numbers with valid and invalid radices under several buffer sizes,
// predicts every character (or the single failure) and checks each result in
// order, with random idle cycles on both handshakes.
// ----------------------------------------------------------------------------
module integer_to_radix_text_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  // bench limits
  localparam int MAX_TEXT_DIGITS = itrt_pkg::MAX_DIGITS_DEF;
  localparam int RADIX_LOW       = 2;
  localparam int RADIX_HIGH      = 16;
  localparam int IDLE_MAX        = 6;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int SETTLE_CYCLES   = 250;
  localparam int REPORT_LIMIT    = 10;

  localparam logic [itrt_pkg::CHAR_W-1:0] ASCII_ZERO    = 8'h30;
  localparam logic [itrt_pkg::CHAR_W-1:0] ASCII_LOWER_A = 8'h61;

  // one character of converted text as seen on the result channel
  typedef struct packed {
    logic [itrt_pkg::CHAR_W-1:0]  digit_char;
    logic                         last_char;
    logic                         failed;
    logic [itrt_pkg::COUNT_W-1:0] digit_count;
  } text_char_t;

  localparam text_char_t FAILED_CHAR = '{digit_char: '0, last_char: 1'b1,
                                         failed: 1'b1, digit_count: '0};

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cfg_wr_en;
  logic [itrt_pkg::BUF_W-1:0] cfg_wr_data;

  itrt_req_if req_ch ();
  itrt_rsp_if rsp_ch ();

  integer_to_radix_text_top uut (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // expected characters, oldest first
  text_char_t pending_chars[$];

  logic [itrt_pkg::BUF_W-1:0] buf_size_model;
  int send_max_gap = IDLE_MAX;
  int recv_max_gap = IDLE_MAX;

  int check_failures = 0;
  int chars_checked  = 0;
  int conversions    = 0;
  int fails_expected = 0;
  int longest_text   = 0;
  int size_writes    = 0;

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int pick_gap(int max_gap);
    if (max_gap == 0) return 0;
    return $urandom_range(0, max_gap);
  endfunction

  function automatic void note_failure(string msg);
    check_failures++;
    if (check_failures <= REPORT_LIMIT) $display("[%0t] %s", $realtime, msg);
  endfunction

  // append one expected character at the tail
  function automatic void add_expected(text_char_t c);
    pending_chars.insert(pending_chars.size(), c);
  endfunction

  // repeated division, digits emitted most significant first
  function automatic void predict_text(logic [itrt_pkg::NUMBER_W-1:0] number,
                                       logic [itrt_pkg::RADIX_W-1:0] radix);
    logic [itrt_pkg::DIGIT_W-1:0]  digits [MAX_TEXT_DIGITS];
    logic [itrt_pkg::NUMBER_W-1:0] quotient;
    logic [itrt_pkg::NUMBER_W-1:0] base;
    int unsigned                   count;
    int unsigned                   limit;
    logic [itrt_pkg::DIGIT_W-1:0]  d;
    text_char_t                    item;
    quotient = number;
    base     = itrt_pkg::NUMBER_W'(radix);
    count    = 0;
    limit    = buf_size_model;
    conversions++;
    if (radix < RADIX_LOW || radix > RADIX_HIGH || limit < 2) begin
      fails_expected++;
      add_expected(FAILED_CHAR);
      return;
    end
    do begin
      digits[count] = itrt_pkg::DIGIT_W'(quotient % base);
      quotient      = quotient / base;
      count++;
    end while (quotient != 0 && count < limit && count < MAX_TEXT_DIGITS);
    // overflow: quotient left, or no room for the terminator
    if (quotient != 0 || count >= limit - 1) begin
      fails_expected++;
      add_expected(FAILED_CHAR);
      return;
    end
    if (count > longest_text) longest_text = count;
    for (int k = 0; k < count; k++) begin
      d = digits[count - 1 - k];
      item.digit_char  = (d >= 4'd10) ? ASCII_LOWER_A + itrt_pkg::CHAR_W'(d) - 8'd10
                                      : ASCII_ZERO + itrt_pkg::CHAR_W'(d);
      item.last_char   = (k + 1 == count);
      item.failed      = 1'b0;
      item.digit_count = itrt_pkg::COUNT_W'(count);
      add_expected(item);
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    text_char_t got;
    text_char_t want;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      got = '{rsp_ch.digit_char, rsp_ch.last_char, rsp_ch.failed, rsp_ch.digit_count};
      chars_checked++;
      if (pending_chars.size() == 0) begin
        note_failure($sformatf("unexpected result char=%h last=%b failed=%b count=%0d",
                               got.digit_char, got.last_char, got.failed,
                               got.digit_count));
      end else begin
        want = pending_chars.pop_front();
        if (got.digit_char !== want.digit_char || got.last_char !== want.last_char ||
            got.failed !== want.failed || got.digit_count !== want.digit_count) begin
          note_failure({
            $sformatf("mismatch: expected char=%h last=%b failed=%b count=%0d",
                      want.digit_char, want.last_char, want.failed, want.digit_count),
            $sformatf(", got char=%h last=%b failed=%b count=%0d",
                      got.digit_char, got.last_char, got.failed, got.digit_count)});
        end
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    int idle_cycles;
    if (rst) begin
      idle_cycles = 0;
    end else if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                 (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no request or result moved for %0d cycles", idle_cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // result sink with random stalls
  initial begin : result_sink
    int stall;
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = pick_gap(recv_max_gap);
      if (stall > 0) begin
        rsp_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready = 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
      @(negedge clk);
    end
  end

  // one request; entered and left at a falling edge, valid left high
  task automatic send_conversion(logic [itrt_pkg::NUMBER_W-1:0] number,
                                 logic [itrt_pkg::RADIX_W-1:0] radix);
    int gap;
    gap = pick_gap(send_max_gap);
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid  = 1'b1;
    req_ch.number = number;
    req_ch.radix  = radix;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    predict_text(number, radix);
    @(negedge clk);
  endtask

  // hold off until every expected character has come back
  task automatic wait_results_drained();
    req_ch.valid = 1'b0;
    while (pending_chars.size() != 0) @(negedge clk);
  endtask

  task automatic set_buffer_size(logic [itrt_pkg::BUF_W-1:0] size);
    wait_results_drained();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = size;
    @(negedge clk);
    cfg_wr_en      = 1'b0;
    buf_size_model = size;
    size_writes++;
  endtask

  function automatic logic [itrt_pkg::NUMBER_W-1:0] draw_number();
    case ($urandom_range(0, 4))
      0:       return $urandom() >> $urandom_range(0, 31);
      1:       return $urandom_range(0, 20);
      2:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [itrt_pkg::RADIX_W-1:0] draw_radix();
    if ($urandom_range(0, 99) < 85) begin
      return itrt_pkg::RADIX_W'($urandom_range(RADIX_LOW, RADIX_HIGH));
    end
    return itrt_pkg::RADIX_W'($urandom_range(0, 31));
  endfunction

  // extremes of number and radix at the reset buffer size
  task automatic test_reset_size_conversions();
    send_conversion(32'd0, 5'd10);
    send_conversion(32'd0, 5'd2);
    send_conversion(32'hFFFF_FFFF, 5'd2);
    send_conversion(32'h8000_0000, 5'd2);
    send_conversion(32'hFFFF_FFFF, 5'd16);
    send_conversion(32'hABCD_EF01, 5'd16);
    send_conversion(32'hFFFF_FFFF, 5'd10);
    send_conversion(32'hFFFF_FFFF, 5'd3);
    send_conversion(32'd12345, 5'd7);
    // radix out of range
    send_conversion($urandom(), 5'd0);
    send_conversion($urandom(), 5'd1);
    send_conversion($urandom(), 5'd17);
    send_conversion($urandom(), 5'd31);
  endtask

  // buffer too small, overflow at the edge of fit, store full
  task automatic test_buffer_size_limits();
    set_buffer_size(8'd0);
    send_conversion(32'd5, 5'd10);
    set_buffer_size(8'd1);
    send_conversion(32'd5, 5'd10);
    set_buffer_size(8'd2);
    send_conversion(32'd0, 5'd10);
    set_buffer_size(8'd3);
    send_conversion(32'd9, 5'd10);
    send_conversion(32'd10, 5'd10);
    set_buffer_size(8'd5);
    send_conversion(32'hFFFF_FFFF, 5'd2);
    set_buffer_size(8'd9);
    send_conversion(32'hFFFF_FFFF, 5'd16);
    set_buffer_size(8'd10);
    send_conversion(32'hFFFF_FFFF, 5'd16);
    set_buffer_size(8'd33);
    send_conversion(32'hFFFF_FFFF, 5'd2);
    set_buffer_size(8'd255);
    send_conversion(32'hFFFF_FFFF, 5'd2);
    send_conversion(32'd0, 5'd16);
    set_buffer_size(itrt_pkg::BUF_SIZE_RESET);
  endtask

  // random conversions across several buffer sizes, with a drain mid-phase
  task automatic test_random_conversions();
    logic [itrt_pkg::BUF_W-1:0] sizes [6];
    int                         counts [6];
    sizes  = '{8'd34, 8'd255,
               itrt_pkg::BUF_W'($urandom_range(0, 1)),
               itrt_pkg::BUF_W'($urandom_range(2, 12)),
               itrt_pkg::BUF_W'($urandom_range(13, 40)),
               itrt_pkg::BUF_W'($urandom_range(41, 254))};
    counts = '{65, 65, 15, 65, 65, 65};
    for (int p = 0; p < 6; p++) begin
      set_buffer_size(sizes[p]);
      for (int i = 0; i < counts[p]; i++) begin
        if (i == counts[p] / 2) wait_results_drained();
        send_conversion(draw_number(), draw_radix());
      end
    end
  endtask

  // back-to-back requests and results, no idle cycles
  task automatic test_back_to_back();
    set_buffer_size(itrt_pkg::BUF_SIZE_RESET);
    send_max_gap = 0;
    recv_max_gap = 0;
    for (int i = 0; i < 60; i++) send_conversion(draw_number(), draw_radix());
    wait_results_drained();
    send_max_gap = IDLE_MAX;
    recv_max_gap = IDLE_MAX;
  endtask

  initial begin
    rst            = 1'b1;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    req_ch.valid   = 1'b0;
    req_ch.number  = '0;
    req_ch.radix   = '0;
    buf_size_model = itrt_pkg::BUF_SIZE_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_size_conversions();
    test_buffer_size_limits();
    test_random_conversions();
    test_back_to_back();

    // drain, then watch for stray results
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_chars.size() != 0)
      note_failure($sformatf("%0d expected results never arrived", pending_chars.size()));

    $display("covered %0d conversions (%0d expected to fail), %0d result chars checked",
             conversions, fails_expected, chars_checked);
    $display("%0d buffer size writes from 0 to 255, longest text %0d digits",
             size_writes, longest_text);
    if (check_failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
